// File: rtl/pidt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the PID thermostat controller.
// Used by every module of the block; depends on nothing else.
package pidt_pkg;

  localparam int TEMP_W    = 13;
  localparam int GAIN_W    = 24;
  localparam int SUM_W     = 32;
  localparam int PERR_W    = 9;
  localparam int DIFF_W    = 10;
  localparam int DRV_W     = 10;
  localparam int OUT_W     = 11;
  localparam int ELAPSED_W = 16;
  localparam int ACC_W     = 58;
  localparam int ACC_FRAC  = 16;

  // Sensor limits: -50 and 200 degrees in 1/16 degree units
  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -13'sd800;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 13'sd3200;
  // 15 degrees of error forces full drive
  localparam logic signed [TEMP_W:0]   ERR_FULL  = 14'sd240;
  localparam logic signed [OUT_W-1:0]  OUT_MAX   = 11'sd1000;
  localparam logic signed [ACC_W-1:0]  ACC_LIM   = 58'sd65536000;
  localparam logic signed [ACC_W-1:0]  ACC_HALF  = 58'sd32768;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_STOP    = 2'd2,
    OP_UNKNOWN = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BUSY        = 3'd1,
    ST_TEMP_FAULT  = 3'd2,
    ST_PARAM_ERR   = 3'd3,
    ST_NOT_RUNNING = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    EV_NONE        = 2'd0,
    EV_REACHED     = 2'd1,
    EV_TIMEOUT     = 2'd2,
    EV_SENSOR_FAIL = 2'd3
  } event_e;

  localparam logic [1:0] MODE_AUTO     = 2'd0;
  localparam logic [1:0] MODE_HEAT     = 2'd1;
  localparam logic [1:0] MODE_COOL     = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [2:0] REG_RUN_MODE   = 3'd0;
  localparam logic [2:0] REG_TARGET     = 3'd1;
  localparam logic [2:0] REG_TOLERANCE  = 3'd2;
  localparam logic [2:0] REG_TIMEOUT    = 3'd3;
  localparam logic [2:0] REG_GAIN_P     = 3'd4;
  localparam logic [2:0] REG_GAIN_I     = 3'd5;
  localparam logic [2:0] REG_GAIN_D     = 3'd6;
  localparam logic [2:0] REG_ACTUATORS  = 3'd7;

  typedef struct packed {
    logic [1:0]               run_mode;
    logic signed [TEMP_W-1:0] target_temp;
    logic signed [TEMP_W-1:0] tolerance_temp;
    logic [ELAPSED_W-1:0]     timeout_ticks;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [1:0]               actuators_present;
  } cfg_t;

  // First member lands in the top bits, so command_status sits at bit 0
  typedef struct packed {
    logic             running;
    logic             stopped_event;
    event_e           event_code;
    logic [DRV_W-1:0] cooler_level;
    logic [DRV_W-1:0] heater_level;
    status_e          command_status;
  } res_t;

endpackage

// File: rtl/pidt_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file behind an APB-style port.
// Depends on pidt_pkg for the register layout.
module pidt_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output pidt_pkg::cfg_t     cfg_o
);
  import pidt_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_RUN_MODE:  cfg_d.run_mode          = pwdata[1:0];
        REG_TARGET:    cfg_d.target_temp       = pwdata[TEMP_W-1:0];
        REG_TOLERANCE: cfg_d.tolerance_temp    = pwdata[TEMP_W-1:0];
        REG_TIMEOUT:   cfg_d.timeout_ticks     = pwdata[ELAPSED_W-1:0];
        REG_GAIN_P:    cfg_d.gain_p            = pwdata[GAIN_W-1:0];
        REG_GAIN_I:    cfg_d.gain_i            = pwdata[GAIN_W-1:0];
        REG_GAIN_D:    cfg_d.gain_d            = pwdata[GAIN_W-1:0];
        REG_ACTUATORS: cfg_d.actuators_present = pwdata[1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RUN_MODE:  prdata = {30'b0, cfg_q.run_mode};
      REG_TARGET:    prdata = {19'b0, cfg_q.target_temp};
      REG_TOLERANCE: prdata = {19'b0, cfg_q.tolerance_temp};
      REG_TIMEOUT:   prdata = {16'b0, cfg_q.timeout_ticks};
      REG_GAIN_P:    prdata = {8'b0, cfg_q.gain_p};
      REG_GAIN_I:    prdata = {8'b0, cfg_q.gain_i};
      REG_GAIN_D:    prdata = {8'b0, cfg_q.gain_d};
      REG_ACTUATORS: prdata = {30'b0, cfg_q.actuators_present};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/pidt_pid.sv
`timescale 1ns / 1ps
// Positional PID arithmetic: saturating integrator, three products, clamp and round.
// Purely combinational; depends on pidt_pkg.
module pidt_pid (
  input  pidt_pkg::cfg_t                          cfg_i,
  input  logic signed [pidt_pkg::TEMP_W-1:0]      temp_i,
  input  logic signed [pidt_pkg::SUM_W-1:0]       sum_i,
  input  logic signed [pidt_pkg::PERR_W-1:0]      perr_i,
  output logic signed [pidt_pkg::OUT_W-1:0]       out_o,
  output logic signed [pidt_pkg::SUM_W-1:0]       sum_o,
  output logic signed [pidt_pkg::PERR_W-1:0]      perr_o
);
  import pidt_pkg::*;

  logic signed [TEMP_W:0]   err;
  logic signed [PERR_W-1:0] err_n;
  logic signed [SUM_W:0]    sum_ext;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [DIFF_W-1:0] diff;
  logic signed [32:0]       p_prod;
  logic signed [55:0]       i_prod;
  logic signed [33:0]       d_prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic                     full_pos, full_neg;

  assign err      = {cfg_i.target_temp[TEMP_W-1], cfg_i.target_temp}
                  - {temp_i[TEMP_W-1], temp_i};
  assign full_pos = err > ERR_FULL;
  assign full_neg = err < -ERR_FULL;
  // Inside the band the error fits the narrow width
  assign err_n    = err[PERR_W-1:0];

  assign sum_ext  = {sum_i[SUM_W-1], sum_i} + (SUM_W+1)'(err_n);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  assign diff    = {err_n[PERR_W-1], err_n} - {perr_i[PERR_W-1], perr_i};
  assign p_prod  = cfg_i.gain_p * err_n;
  assign i_prod  = cfg_i.gain_i * sum_sat;
  assign d_prod  = cfg_i.gain_d * diff;
  assign acc     = ACC_W'(p_prod) + ACC_W'(i_prod) + ACC_W'(d_prod);
  assign acc_rnd = acc + ACC_HALF;

  always_comb begin
    sum_o  = sum_i;
    perr_o = perr_i;
    if (full_pos) begin
      out_o = OUT_MAX;
    end else if (full_neg) begin
      out_o = -OUT_MAX;
    end else begin
      sum_o  = sum_sat;
      perr_o = err_n;
      if (acc > ACC_LIM) begin
        out_o = OUT_MAX;
      end else if (acc < -ACC_LIM) begin
        out_o = -OUT_MAX;
      end else begin
        // shifted value rounded half up, already within the output range
        out_o = acc_rnd[ACC_FRAC+OUT_W-1:ACC_FRAC];
      end
    end
  end

endmodule

// File: rtl/pidt_core.sv
`timescale 1ns / 1ps
// Run state of the thermostat: command checks, fault counting, reached and
// timeout detection, drive split and stop handling. Depends on pidt_pkg, pidt_pid.
module pidt_core #(
  parameter int FAULT_LIMIT = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  pidt_pkg::op_e                        op_i,
  input  logic signed [pidt_pkg::TEMP_W-1:0]   temp_i,
  input  pidt_pkg::cfg_t                       cfg_i,
  output pidt_pkg::res_t                       res_o
);
  import pidt_pkg::*;

  localparam int FC_W = $clog2(FAULT_LIMIT + 1);

  logic                     busy_q, busy_d;
  logic                     reached_q, reached_d;
  logic                     above_q, above_d;
  logic                     stop_pending_q, stop_pending_d;
  logic                     fault_flag_q, fault_flag_d;
  logic [FC_W-1:0]          fault_count_q, fault_count_d, fc_inc;
  logic [ELAPSED_W-1:0]     elapsed_q, elapsed_d, elapsed_inc;
  logic signed [SUM_W-1:0]  sum_q, sum_d, pid_sum;
  logic signed [PERR_W-1:0] perr_q, perr_d, pid_perr;
  logic [DRV_W-1:0]         heat_q, heat_d, cool_q, cool_d;
  logic [DRV_W-1:0]         pos_mag, neg_mag;
  logic signed [OUT_W-1:0]  pid_out, pid_neg;
  logic signed [TEMP_W:0]   temp_x, band_hi, band_lo;
  logic                     in_range, need_h, need_c, cfg_ok, hit;
  status_e                  status;
  event_e                   ev;
  logic                     stopped;

  pidt_pid u_pid (
    .cfg_i  (cfg_i),
    .temp_i (temp_i),
    .sum_i  (sum_q),
    .perr_i (perr_q),
    .out_o  (pid_out),
    .sum_o  (pid_sum),
    .perr_o (pid_perr)
  );

  assign pid_neg  = -pid_out;
  assign pos_mag  = pid_out[OUT_W-1] ? '0 : pid_out[DRV_W-1:0];
  assign neg_mag  = pid_out[OUT_W-1] ? pid_neg[DRV_W-1:0] : '0;

  assign in_range = (temp_i > TEMP_LOW) && (temp_i < TEMP_HIGH);
  assign need_h   = (cfg_i.run_mode == MODE_AUTO) || (cfg_i.run_mode == MODE_HEAT);
  assign need_c   = (cfg_i.run_mode == MODE_AUTO) || (cfg_i.run_mode == MODE_COOL);
  assign cfg_ok   = (cfg_i.target_temp > TEMP_LOW) && (cfg_i.target_temp < TEMP_HIGH)
                 && !cfg_i.tolerance_temp[TEMP_W-1] && (cfg_i.timeout_ticks != '0);

  assign temp_x   = {temp_i[TEMP_W-1], temp_i};
  assign band_hi  = {cfg_i.target_temp[TEMP_W-1], cfg_i.target_temp}
                  + {cfg_i.tolerance_temp[TEMP_W-1], cfg_i.tolerance_temp};
  assign band_lo  = {cfg_i.target_temp[TEMP_W-1], cfg_i.target_temp}
                  - {cfg_i.tolerance_temp[TEMP_W-1], cfg_i.tolerance_temp};
  assign hit      = above_q ? (temp_x <= band_hi) : (temp_x >= band_lo);

  assign fc_inc      = fault_count_q + 1'b1;
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

  always_comb begin
    busy_d         = busy_q;
    reached_d      = reached_q;
    above_d        = above_q;
    stop_pending_d = stop_pending_q;
    fault_flag_d   = fault_flag_q;
    fault_count_d  = fault_count_q;
    elapsed_d      = elapsed_q;
    sum_d          = sum_q;
    perr_d         = perr_q;
    heat_d         = heat_q;
    cool_d         = cool_q;
    status         = ST_OK;
    ev             = EV_NONE;
    stopped        = 1'b0;

    case (op_i)
      OP_START: begin
        if (busy_q) begin
          status = ST_BUSY;
        end else if (!in_range) begin
          status = ST_TEMP_FAULT;
        end else if ((need_h && !cfg_i.actuators_present[0])
                  || (need_c && !cfg_i.actuators_present[1])
                  || (cfg_i.run_mode == MODE_RESERVED) || !cfg_ok) begin
          status = ST_PARAM_ERR;
        end else begin
          busy_d         = 1'b1;
          reached_d      = 1'b0;
          stop_pending_d = 1'b0;
          fault_flag_d   = 1'b0;
          fault_count_d  = '0;
          elapsed_d      = '0;
          sum_d          = '0;
          perr_d         = '0;
          heat_d         = '0;
          cool_d         = '0;
          above_d        = temp_i >= cfg_i.target_temp;
        end
      end
      OP_STOP: begin
        if (busy_q) begin
          stop_pending_d = 1'b1;
        end else begin
          status = ST_NOT_RUNNING;
        end
      end
      OP_UNKNOWN: begin
        status = ST_PARAM_ERR;
      end
      OP_TICK: begin
        if (!busy_q) begin
          status = ST_NOT_RUNNING;
        end else begin
          if (!in_range) begin
            if (fc_inc >= FC_W'(FAULT_LIMIT)) begin
              fault_count_d  = '0;
              ev             = EV_SENSOR_FAIL;
              stop_pending_d = 1'b1;
              fault_flag_d   = 1'b1;
            end else begin
              fault_count_d = fc_inc;
            end
          end else begin
            fault_count_d = '0;
            if (!reached_q) begin
              elapsed_d = elapsed_inc;
              if (hit) begin
                reached_d = 1'b1;
                ev        = EV_REACHED;
              end else if (elapsed_inc >= cfg_i.timeout_ticks) begin
                reached_d = 1'b1;
                ev        = EV_TIMEOUT;
              end
            end
            // reserved mode leaves the loop and the drives untouched
            if (cfg_i.run_mode != MODE_RESERVED) begin
              sum_d  = pid_sum;
              perr_d = pid_perr;
              if (cfg_i.run_mode == MODE_AUTO) begin
                heat_d = pos_mag;
                cool_d = neg_mag;
              end else if (cfg_i.run_mode == MODE_HEAT) begin
                heat_d = pos_mag;
              end else begin
                cool_d = neg_mag;
              end
            end
            // one-sided modes count as reached once the reading passes the target
            if (!reached_d && (((cfg_i.run_mode == MODE_COOL) && (cfg_i.target_temp > temp_i))
                || ((cfg_i.run_mode == MODE_HEAT) && (temp_i > cfg_i.target_temp)))) begin
              reached_d = 1'b1;
              ev        = EV_REACHED;
            end
          end
          if (stop_pending_d) begin
            stop_pending_d = 1'b0;
            heat_d         = '0;
            cool_d         = '0;
            busy_d         = 1'b0;
            if (!fault_flag_d) begin
              stopped = 1'b1;
            end else begin
              fault_flag_d = 1'b0;
            end
          end
        end
      end
      default: begin
        status = ST_PARAM_ERR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      reached_q      <= 1'b0;
      above_q        <= 1'b0;
      stop_pending_q <= 1'b0;
      fault_flag_q   <= 1'b0;
      fault_count_q  <= '0;
      elapsed_q      <= '0;
      sum_q          <= '0;
      perr_q         <= '0;
      heat_q         <= '0;
      cool_q         <= '0;
    end else if (step_i) begin
      busy_q         <= busy_d;
      reached_q      <= reached_d;
      above_q        <= above_d;
      stop_pending_q <= stop_pending_d;
      fault_flag_q   <= fault_flag_d;
      fault_count_q  <= fault_count_d;
      elapsed_q      <= elapsed_d;
      sum_q          <= sum_d;
      perr_q         <= perr_d;
      heat_q         <= heat_d;
      cool_q         <= cool_d;
    end
  end

  assign res_o.running        = busy_d;
  assign res_o.stopped_event  = stopped;
  assign res_o.event_code     = ev;
  assign res_o.cooler_level   = cool_d;
  assign res_o.heater_level   = heat_d;
  assign res_o.command_status = status;

  a_idle_drives_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (heat_q == '0) && (cool_q == '0))
    else $error("drive left on while idle");

  a_idle_no_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !stop_pending_q && !fault_flag_q)
    else $error("stop or fault pending while idle");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heat_q <= DRV_W'(1000)) && (cool_q <= DRV_W'(1000)))
    else $error("drive level above full scale");

  a_fault_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_count_q < FC_W'(FAULT_LIMIT))
    else $error("fault counter passed its limit");

  a_stop_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (op_i == OP_STOP) && busy_q |=> busy_q && stop_pending_q)
    else $error("stop request not held until the next tick");

endmodule

// File: rtl/pid_thermostat_controller.sv
`timescale 1ns / 1ps
// PID thermostat controller, top level: stream handshake, input and result
// registers, configuration port. Depends on pidt_pkg, pidt_cfg_regs, pidt_core.
//
// Each request (tick, start or stop, with a sensor reading) is taken into an
// input register and answered with one result in the output register; a
// request can be accepted on every clock cycle while the result stream is not
// stalled, and the input side keeps accepting while a result waits as long as
// the output register frees in the same cycle. The whole step, including the
// saturating integrator add, the three gain products and the clamp and round,
// is combinational between the two registers, so that path sets the clock rate.
// Registers are live: write them only while no request is in flight. No clearing
// pass runs after reset; the block is ready as soon as reset is released.
module pid_thermostat_controller #(
  parameter int FAULT_LIMIT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [12:0] temperature, [15:13] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [2:0] command_status, [12:3] heater_level,
                                      // [22:13] cooler_level, [24:23] event_code,
                                      // [25] stopped_event, [26] running, [31:27] zero
);
  import pidt_pkg::*;

  cfg_t                    cfg;
  res_t                    res;
  res_t                    out_data_q;
  logic                    in_valid_q, out_valid_q;
  op_e                     in_op_q;
  logic signed [TEMP_W-1:0] in_temp_q;
  logic                    fire, accept;

  assign pready = 1'b1;

  pidt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // advance the held request whenever the result register is free or drains
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  pidt_core #(
    .FAULT_LIMIT (FAULT_LIMIT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .op_i   (in_op_q),
    .temp_i (in_temp_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q   <= op_e'(s_axis_tuser);
      in_temp_q <= s_axis_tdata[TEMP_W-1:0];
    end
    if (fire) begin
      out_data_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_data_q};

endmodule
